/* design/cbb_pkg.sv */
// ----------------------------------------------------------------------------
// cbb_pkg: shared types and constants for the character class bitmap builder
// Item and result transactions, the front-to-back operation word, and the
// escape decode table.
// ----------------------------------------------------------------------------
`default_nettype none

package cbb_pkg;

  localparam int unsigned BitmapBits  = 256;
  localparam int unsigned BitmapBytes = 32;

  localparam logic [7:0] ChrCaret  = 8'h5E;
  localparam logic [7:0] ChrDash   = 8'h2D;
  localparam logic [7:0] ChrBslash = 8'h5C;
  localparam logic [7:0] AllOnesByte = 8'hFF;
  localparam logic [4:0] LastIndex = 5'(BitmapBytes - 1);

  // request codes
  localparam logic REQ_CHAR   = 1'b0;
  localparam logic REQ_FINISH = 1'b1;

  typedef struct packed {
    logic       req_type;
    logic [7:0] char_code;
  } cbb_item_t;

  typedef struct packed {
    logic [4:0] byte_index;
    logic [7:0] byte_value;
    logic       last_byte;
  } cbb_result_t;

  // operation kinds handed from front to back
  typedef enum logic [1:0] {
    OP_MARK    = 2'd0,
    OP_SET_ALL = 2'd1,
    OP_FINISH  = 2'd2
  } cbb_op_kind_t;

  typedef struct packed {
    cbb_op_kind_t kind;
    logic         neg;       // clear instead of set
    logic         has_mark;  // finish: apply lo..hi before emitting
    logic [7:0]   lo;
    logic [7:0]   hi;
  } cbb_op_t;

  // escape letter decode
  function automatic logic [7:0] unescape(input logic [7:0] c);
    logic [7:0] v;
    v = c;
    unique case (c)
      8'h61:   v = 8'd7;   // a
      8'h62:   v = 8'd8;   // b
      8'h65:   v = 8'd27;  // e
      8'h66:   v = 8'd12;  // f
      8'h6E:   v = 8'd10;  // n
      8'h72:   v = 8'd13;  // r
      8'h74:   v = 8'd9;   // t
      8'h76:   v = 8'd11;  // v
      default: v = c;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* design/cbb_front.sv */
// ----------------------------------------------------------------------------
// cbb_front: class text parser
// Accepts item transactions, tracks caret, dash and escape context and turns
// each item into at most one bitmap operation for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_front (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              push,
  input  wire logic              full,
  input  wire cbb_pkg::cbb_item_t item,
  output logic                   op_push,
  output cbb_pkg::cbb_op_t       op
);

  logic       accept;
  logic [7:0] prev_char, prev_char_next;
  logic       prev_valid, prev_valid_next;
  logic       neg, neg_next;
  logic       at_start, at_start_next;
  logic       dash_pend, dash_pend_next;
  logic       esc_pend, esc_pend_next;
  logic [7:0] c;
  logic [7:0] esc_char;

  assign accept   = push && !full;
  assign c        = item.char_code;
  assign esc_char = cbb_pkg::unescape(c);

  // parse context and operation decode
  always_comb begin
    prev_char_next  = prev_char;
    prev_valid_next = prev_valid;
    neg_next        = neg;
    at_start_next   = at_start;
    dash_pend_next  = dash_pend;
    esc_pend_next   = esc_pend;
    op_push         = 1'b0;
    op.kind         = cbb_pkg::OP_MARK;
    op.neg          = neg;
    op.has_mark     = 1'b0;
    op.lo           = c;
    op.hi           = c;
    if (accept) begin
      if (item.req_type == cbb_pkg::REQ_CHAR) begin
        at_start_next = 1'b0;
        if (at_start && c == cbb_pkg::ChrCaret) begin
          neg_next = 1'b1;
          op_push  = 1'b1;
          op.kind  = cbb_pkg::OP_SET_ALL;
        end else if (esc_pend) begin
          esc_pend_next   = 1'b0;
          op_push         = 1'b1;
          op.lo           = esc_char;
          op.hi           = esc_char;
          prev_char_next  = esc_char;
          prev_valid_next = 1'b1;
        end else if (dash_pend) begin
          dash_pend_next  = 1'b0;
          prev_valid_next = 1'b0;
          op_push         = 1'b1;
          op.lo           = prev_char;
          op.hi           = c;
        end else if (c == cbb_pkg::ChrDash && prev_valid) begin
          dash_pend_next = 1'b1;
        end else if (c == cbb_pkg::ChrBslash) begin
          esc_pend_next = 1'b1;
        end else begin
          op_push         = 1'b1;
          prev_char_next  = c;
          prev_valid_next = 1'b1;
        end
      end else begin
        // finish: a dangling dash or backslash is a literal
        op_push         = 1'b1;
        op.kind         = cbb_pkg::OP_FINISH;
        op.has_mark     = dash_pend || esc_pend;
        op.lo           = dash_pend ? cbb_pkg::ChrDash : cbb_pkg::ChrBslash;
        op.hi           = dash_pend ? cbb_pkg::ChrDash : cbb_pkg::ChrBslash;
        prev_char_next  = 8'd0;
        prev_valid_next = 1'b0;
        neg_next        = 1'b0;
        at_start_next   = 1'b1;
        dash_pend_next  = 1'b0;
        esc_pend_next   = 1'b0;
      end
    end
  end

  // context registers
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_char  <= 8'd0;
      prev_valid <= 1'b0;
      neg        <= 1'b0;
      at_start   <= 1'b1;
      dash_pend  <= 1'b0;
      esc_pend   <= 1'b0;
    end else begin
      prev_char  <= prev_char_next;
      prev_valid <= prev_valid_next;
      neg        <= neg_next;
      at_start   <= at_start_next;
      dash_pend  <= dash_pend_next;
      esc_pend   <= esc_pend_next;
    end
  end

endmodule

`default_nettype wire

/* design/cbb_fifo.sv */
// ----------------------------------------------------------------------------
// cbb_fifo: operation queue
// Four-entry queue between the parser and the bitmap back end.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             wr_en,
  input  wire cbb_pkg::cbb_op_t wr_op,
  input  wire logic             rd_en,
  output logic                  full,
  output logic                  empty,
  output cbb_pkg::cbb_op_t      head
);

  cbb_pkg::cbb_op_t slots [4];
  logic [1:0] wr_ptr;
  logic [1:0] rd_ptr;
  logic [2:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full  = (count == 3'd4);
  assign empty = (count == 3'd0);
  assign head  = slots[rd_ptr];
  assign do_wr = wr_en && !full;
  assign do_rd = rd_en && !empty;

  // entry storage
  always_ff @(posedge clk) begin
    if (do_wr) begin
      slots[wr_ptr] <= wr_op;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      if (do_wr) begin
        wr_ptr <= wr_ptr + 2'd1;
      end
      if (do_rd) begin
        rd_ptr <= rd_ptr + 2'd1;
      end
      if (do_wr && !do_rd) begin
        count <= count + 3'd1;
      end else if (do_rd && !do_wr) begin
        count <= count - 3'd1;
      end
    end
  end

endmodule

`default_nettype wire

/* design/cbb_back.sv */
// ----------------------------------------------------------------------------
// cbb_back: bitmap update and drain
// Applies queued operations to the 256-bit bitmap with a parallel range mask
// and drains a finished bitmap one byte per result transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module cbb_back (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             q_empty,
  input  wire cbb_pkg::cbb_op_t q_head,
  output logic                  q_pop,
  input  wire logic             pop,
  output logic                  empty,
  output cbb_pkg::cbb_result_t  result
);

  logic [cbb_pkg::BitmapBits-1:0] bitmap;
  logic [cbb_pkg::BitmapBits-1:0] shadow;
  logic [cbb_pkg::BitmapBits-1:0] mask;
  logic [cbb_pkg::BitmapBits-1:0] marked;
  logic [4:0] idx;
  logic       busy;
  logic       out_take;
  logic       last_take;

  assign out_take  = busy && pop;
  assign last_take = out_take && (idx == cbb_pkg::LastIndex);

  // inclusive lo..hi mask, empty when lo is above hi
  always_comb begin
    mask   = ({cbb_pkg::BitmapBits{1'b1}} << q_head.lo)
           & ({cbb_pkg::BitmapBits{1'b1}} >> (cbb_pkg::AllOnesByte - q_head.hi));
    marked = q_head.neg ? (bitmap & ~mask) : (bitmap | mask);
  end

  // a finish waits until the drain register is free
  assign q_pop = !q_empty
              && (q_head.kind != cbb_pkg::OP_FINISH || !busy || last_take);

  // bitmap update
  always_ff @(posedge clk) begin
    if (rst) begin
      bitmap <= '0;
    end else if (q_pop) begin
      unique case (q_head.kind)
        cbb_pkg::OP_MARK:    bitmap <= marked;
        cbb_pkg::OP_SET_ALL: bitmap <= '1;
        cbb_pkg::OP_FINISH:  bitmap <= '0;
        default:             bitmap <= bitmap;
      endcase
    end
  end

  // drain register and byte counter
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 5'd0;
    end else begin
      if (out_take) begin
        idx <= idx + 5'd1;
        if (idx == cbb_pkg::LastIndex) begin
          busy <= 1'b0;
        end
      end
      if (q_pop && q_head.kind == cbb_pkg::OP_FINISH) begin
        busy <= 1'b1;
        idx  <= 5'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && q_head.kind == cbb_pkg::OP_FINISH) begin
      shadow <= q_head.has_mark ? marked : bitmap;
    end else if (out_take) begin
      shadow <= shadow >> 8;
    end
  end

  // result transaction
  assign empty             = !busy;
  assign result.byte_index = idx;
  assign result.byte_value = shadow[7:0];
  assign result.last_byte  = (idx == cbb_pkg::LastIndex);

endmodule

`default_nettype wire

/* design/char_class_bitmap_builder.sv */
// ----------------------------------------------------------------------------
// char_class_bitmap_builder: regex character class to 256-bit bitmap
// Parser front end, four-entry operation queue, bitmap back end with drain.
// ----------------------------------------------------------------------------
// Class text is taken one byte per cycle while full is low; a dash or
// backslash that only opens a range or an escape is absorbed without
// touching the bitmap, and a range is applied as a single parallel 256-bit
// mask. A finish transaction produces 32 result transactions, one byte each,
// in index order, at most one per cycle as pop allows; the single byte-wide
// result port sets that figure. Text of the next class is accepted during the
// drain, and a second finish waits in the queue until the previous bitmap has
// drained, so push may see full once the four-entry queue fills behind it.
`default_nettype none

module char_class_bitmap_builder (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 push,
  output logic                      full,
  input  wire cbb_pkg::cbb_item_t   item,
  output logic                      empty,
  input  wire logic                 pop,
  output cbb_pkg::cbb_result_t      result
);

  logic             op_push;
  cbb_pkg::cbb_op_t op;
  logic             q_full;
  logic             q_empty;
  logic             q_pop;
  cbb_pkg::cbb_op_t q_head;

  assign full = q_full;

  // parser
  cbb_front u_front (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .full    (q_full),
    .item    (item),
    .op_push (op_push),
    .op      (op)
  );

  // operation queue
  cbb_fifo u_fifo (
    .clk   (clk),
    .rst   (rst),
    .wr_en (op_push),
    .wr_op (op),
    .rd_en (q_pop),
    .full  (q_full),
    .empty (q_empty),
    .head  (q_head)
  );

  // bitmap and drain
  cbb_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_empty (q_empty),
    .q_head  (q_head),
    .q_pop   (q_pop),
    .pop     (pop),
    .empty   (empty),
    .result  (result)
  );

  // reset leaves no bitmap to drain
  a_reset_empty: assert property (@(posedge clk) rst |=> empty)
    else $error("result side not empty after reset");

  // bytes of one bitmap come out in index order
  a_index_step: assert property (@(posedge clk) disable iff (rst)
    (!empty && pop && !result.last_byte)
      |=> (!empty && result.byte_index == $past(result.byte_index) + 5'd1))
    else $error("bitmap byte index did not advance");

  // a drain never starts in the middle of a bitmap
  a_drain_start: assert property (@(posedge clk) disable iff (rst)
    (!empty && result.byte_index != 5'd0) |-> $past(!empty))
    else $error("drain started at a nonzero byte index");

endmodule

`default_nettype wire
